FILE: sv/perimeter_keyed_insertion_sorter_assert.svh
// Assertion macros used by the checker file of the sorter.
// Both expect a signal named aclk, and PKIS_ASSERT also aresetn, in the enclosing scope.
`ifndef PERIMETER_KEYED_INSERTION_SORTER_ASSERT_SVH
`define PERIMETER_KEYED_INSERTION_SORTER_ASSERT_SVH

// Property checked only while reset is released.
`define PKIS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sorter assertion failed");

// Property checked on every edge, reset included.
`define PKIS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("sorter reset assertion failed");

`endif

FILE: sv/pkis_pkg.sv
package pkis_pkg;

    // Field widths.
    localparam int DIM_W    = 16;
    localparam int PRICE_W  = 16;
    localparam int PERIM_W  = 19;
    localparam int PROD_W   = 34;
    localparam int ROOT_W   = 17;
    localparam int REM_W    = 19;
    localparam int STEP_W   = 5;
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 5;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 4;

    // Pi in Q2.16.
    localparam logic [17:0] PI_Q16 = 18'd205887;

    // Square root steps: one result bit per step.
    localparam logic [STEP_W-1:0] SQRT_STEPS = 5'd17;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CIRCLE   = 2'd0,
        KIND_RECT     = 2'd1,
        KIND_TRIANGLE = 2'd2,
        KIND_SQUARE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BAD_KIND = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_CALC,
        CTL_PUT,
        CTL_READ
    } ctl_state_t;

    typedef enum logic [2:0] {
        PU_IDLE,
        PU_MUL,
        PU_ADD,
        PU_SQRT,
        PU_DONE
    } pu_state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [PERIM_W-1:0] perim;
        logic [PRICE_W-1:0] price;
    } entry_t;

    // Broadcast control for the row of sort cells.
    typedef struct packed {
        logic   insert;
        logic   rotate;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

FILE: sv/perimeter_keyed_insertion_sorter.sv
// Insert: circle, rectangle and square take their key straight from the multiply step; a
// right triangle waits further for the 17-step square root unit, which makes it the slowest.
// Readout: one result beat per cycle while m_tready is high; clear and bad kind answer from the decode state.
// One item is in work at a time; the next is accepted once the result is registered.
// Synchronous active-low reset empties the store and clears all control state.
module perimeter_keyed_insertion_sorter
    import pkis_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // dim_a [15:0], dim_b [31:16], unit_price [47:32]
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation [1:0], shape_kind [4:2]
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // perimeter [18:0], unit_price_res [34:19], zero [39:35]
    output logic [M_DATA_W-1:0] m_tdata,
    // shape_kind_res [1:0], status [3:2]
    output logic [M_USER_W-1:0] m_tuser,
    output logic                m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    ctl_state_t         state_reg, state_next;
    op_t                op_reg;
    logic [2:0]         kind_reg;
    logic [DIM_W-1:0]   a_reg;
    logic [DIM_W-1:0]   b_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_reg, rd_next;
    logic               m_valid_reg, m_valid_next;
    entry_t             out_entry_reg, out_entry_next;
    status_t            out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               pu_start;
    logic               pu_done;
    logic [PERIM_W-1:0] pu_perim;
    cell_ctrl_t         ctrl;
    entry_t             cell_q  [CAPACITY];
    logic               cell_gt [CAPACITY];
    logic [CNT_W-1:0]   count_m1;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == CTL_IDLE);
    assign count_m1 = count_reg - 1'b1;

    // Perimeter unit.
    pkis_perim u_perim (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pu_start),
        .kind    (kind_t'(kind_reg[1:0])),
        .dim_a   (a_reg),
        .dim_b   (b_reg),
        .done    (pu_done),
        .perim   (pu_perim)
    );

    // Row of sort cells, cell 0 holding the smallest key.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   left_gt;

        if (g == 0) begin : g_first
            assign left_entry = cell_q[0];
            assign left_gt    = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_q[g-1];
            assign left_gt    = cell_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = cell_q[0];
        end else begin : g_inner
            assign right_entry = cell_q[g+1];
        end

        pkis_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(g) < count_reg),
            .wrap        (CNT_W'(g) == count_m1),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .head_entry  (cell_q[0]),
            .gt          (cell_gt[g]),
            .entry       (cell_q[g])
        );
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTL_IDLE;
            count_reg   <= '0;
            rd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_reg      <= rd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= op_t'(s_tuser[1:0]);
            kind_reg  <= s_tuser[4:2];
            a_reg     <= s_tdata[15:0];
            b_reg     <= s_tdata[31:16];
            price_reg <= s_tdata[47:32];
        end
        out_entry_reg  <= out_entry_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Sequencer: decode the item, wait for the key, insert or stream out.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        pu_start        = 1'b0;
        ctrl.insert     = 1'b0;
        ctrl.rotate     = 1'b0;
        ctrl.new_entry  = '{kind: kind_reg[1:0], perim: pu_perim, price: price_reg};
        case (state_reg)
            CTL_IDLE: begin
                if (s_tvalid) begin
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC: begin
                case (op_reg)
                    OP_INSERT: begin
                        if (kind_reg[2]) begin
                            if (out_free) begin
                                m_valid_next    = 1'b1;
                                out_entry_next  = '0;
                                out_status_next = STAT_BAD_KIND;
                                out_last_next   = 1'b1;
                                state_next      = CTL_IDLE;
                            end
                        end else begin
                            pu_start   = 1'b1;
                            state_next = CTL_CALC;
                        end
                    end
                    OP_READ: begin
                        if (count_reg == '0) begin
                            if (out_free) begin
                                m_valid_next    = 1'b1;
                                out_entry_next  = '0;
                                out_status_next = STAT_EMPTY;
                                out_last_next   = 1'b1;
                                state_next      = CTL_IDLE;
                            end
                        end else begin
                            rd_next    = '0;
                            state_next = CTL_READ;
                        end
                    end
                    OP_CLEAR: begin
                        if (out_free) begin
                            count_next      = '0;
                            m_valid_next    = 1'b1;
                            out_entry_next  = '0;
                            out_status_next = STAT_OK;
                            out_last_next   = 1'b1;
                            state_next      = CTL_IDLE;
                        end
                    end
                    default: begin
                        state_next = CTL_IDLE;
                    end
                endcase
            end
            CTL_CALC: begin
                if (pu_done) begin
                    state_next = CTL_PUT;
                end
            end
            CTL_PUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_entry_next = ctrl.new_entry;
                    out_last_next  = 1'b1;
                    if (count_reg == CAP_C) begin
                        out_status_next = STAT_FULL;
                    end else begin
                        out_status_next = STAT_OK;
                        ctrl.insert     = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                    state_next = CTL_IDLE;
                end
            end
            CTL_READ: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_entry_next  = cell_q[0];
                    out_status_next = STAT_OK;
                    out_last_next   = (rd_reg == count_m1);
                    ctrl.rotate     = 1'b1;
                    rd_next         = rd_reg + 1'b1;
                    if (rd_reg == count_m1) begin
                        state_next = CTL_IDLE;
                    end
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // Result beat.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_entry_reg.price, out_entry_reg.perim};
    assign m_tuser  = {out_status_reg, out_entry_reg.kind};
    assign m_tlast  = out_last_reg;

endmodule

FILE: sv/pkis_perim.sv
module pkis_perim
    import pkis_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  kind_t              kind,
    input  logic [DIM_W-1:0]   dim_a,
    input  logic [DIM_W-1:0]   dim_b,
    output logic               done,
    output logic [PERIM_W-1:0] perim
);

    pu_state_t          state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [DIM_W-1:0]   a_reg, a_next;
    logic [DIM_W-1:0]   b_reg, b_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PERIM_W-1:0] perim_reg, perim_next;

    logic [DIM_W-1:0]   mul_x;
    logic [17:0]        mul_y;
    logic [PROD_W-1:0]  product;
    logic [REM_W+1:0]   trial_rem;
    logic [REM_W+1:0]   trial;
    logic               trial_ok;
    logic [ROOT_W-1:0]  root_step;
    logic [DIM_W:0]     sum_ab;

    // One shared multiplier: a*pi or a*a first, then b*b for the triangle.
    always_comb begin
        if (state_reg == PU_ADD) begin
            mul_x = b_reg;
            mul_y = {2'b00, b_reg};
        end else begin
            mul_x = a_reg;
            mul_y = (kind_reg == KIND_CIRCLE) ? PI_Q16 : {2'b00, a_reg};
        end
    end

    assign product = {18'b0, mul_x} * {16'b0, mul_y};
    assign sum_ab  = {1'b0, a_reg} + {1'b0, b_reg};

    // Restoring square root step: two radicand bits in, one root bit out.
    assign trial_rem = {rem_reg, prod_reg[PROD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign trial_ok  = trial_rem >= trial;
    assign root_step = {root_reg[ROOT_W-2:0], trial_ok};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        step_reg  <= step_next;
        perim_reg <= perim_next;
    end

    // Sequencer for the perimeter of one shape.
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        perim_next = perim_reg;
        case (state_reg)
            PU_IDLE: begin
                if (start) begin
                    kind_next  = kind;
                    a_next     = dim_a;
                    b_next     = dim_b;
                    state_next = PU_MUL;
                end
            end
            PU_MUL: begin
                prod_next  = product;
                state_next = PU_DONE;
                case (kind_reg)
                    KIND_CIRCLE: perim_next = product[PROD_W-1:15];
                    KIND_RECT:   perim_next = {1'b0, sum_ab, 1'b0};
                    KIND_SQUARE: perim_next = {1'b0, a_reg, 2'b00};
                    default:     state_next = PU_ADD;
                endcase
            end
            PU_ADD: begin
                prod_next  = prod_reg + product;
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = PU_SQRT;
            end
            PU_SQRT: begin
                if (trial_ok) begin
                    rem_next = REM_W'(trial_rem - trial);
                end else begin
                    rem_next = REM_W'(trial_rem);
                end
                root_next = root_step;
                prod_next = {prod_reg[PROD_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == SQRT_STEPS - 1'b1) begin
                    // Every triangle perimeter fits in the key width.
                    perim_next = {2'b00, sum_ab} + {2'b00, root_step};
                    state_next = PU_DONE;
                end
            end
            PU_DONE: begin
                state_next = PU_IDLE;
            end
            default: begin
                state_next = PU_IDLE;
            end
        endcase
    end

    assign done  = (state_reg == PU_DONE);
    assign perim = perim_reg;

endmodule

FILE: sv/pkis_cell.sv
module pkis_cell
    import pkis_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       wrap,
    input  logic       left_gt,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    input  entry_t     head_entry,
    output logic       gt,
    output entry_t     entry
);

    entry_t entry_reg, entry_next;

    // Held key is above the new one: this cell moves right on insert.
    assign gt = occupied && (entry_reg.perim > ctrl.new_entry.perim);

    // On insert, take the left neighbor if it moves too, else the new entry.
    // On readout, rotate left; the last occupied cell takes the head.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert && (gt || !occupied)) begin
            entry_next = left_gt ? left_entry : ctrl.new_entry;
        end else if (ctrl.rotate && occupied) begin
            entry_next = wrap ? head_entry : right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: sv/pkis_checker.sv
`include "perimeter_keyed_insertion_sorter_assert.svh"

module pkis_checker
    import pkis_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser,
    input logic                m_tlast
);

    // No result beat is offered in the cycle after reset.
    `PKIS_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_tvalid)

    // One item at a time: the input is busy right after a beat is taken.
    `PKIS_ASSERT(a_accept_busy, s_tvalid && s_tready |=> !s_tready)

    // A stalled result beat keeps its payload.
    `PKIS_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

    // Full, bad kind and empty answers are single beats.
    `PKIS_ASSERT(a_single_beat, m_tvalid && m_tuser[3:2] != STAT_OK |-> m_tlast)

    // Bad kind and empty answers, the two highest codes, carry an all-zero entry.
    `PKIS_ASSERT(a_zero_entry, m_tvalid && m_tuser[3:2] >= STAT_BAD_KIND |-> m_tdata == '0 && m_tuser[1:0] == 2'b00)

endmodule

bind perimeter_keyed_insertion_sorter pkis_checker u_pkis_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import pkis_pkg::*;

    localparam int STORE_DEPTH = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_CYCLES = 40;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int LONG_HOLD = 800;
    localparam logic [63:0] PI_FIX = 64'd205887;
    localparam logic [63:0] PERIM_CAP = 64'd524287;
    localparam logic [2:0] KIND_BAD_LO = 3'd4;
    localparam logic [2:0] KIND_BAD_MID = 3'd5;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;

    // One result beat as the block should emit it.
    typedef struct packed {
        logic [1:0]         kind;
        logic [PERIM_W-1:0] perim;
        logic [PRICE_W-1:0] price;
        status_t            status;
        logic               last;
    } sorter_beat_t;

    // One input item, with an optional hand-written result.
    typedef struct {
        op_t              op;
        logic [2:0]       kind;
        logic [DIM_W-1:0] dim_a;
        logic [DIM_W-1:0] dim_b;
        logic [PRICE_W-1:0] price;
        bit               known;
        sorter_beat_t     want;
    } shape_item_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    // Shadow copy of the sorted list.
    entry_t shadow_list [STORE_DEPTH];
    int     shadow_count = 0;

    sorter_beat_t pending_beats[$];
    int  err_count = 0;
    int  sent_items = 0;
    int  cycle_cnt = 0;
    bit  quiet = 1'b0;
    bit  rand_started = 1'b0;
    logic hold_long = 1'b0;

    perimeter_keyed_insertion_sorter #(
        .CAPACITY(STORE_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Gap lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Perimeter in whole units of the dimensions, rounded down and clamped to the key width.
    function automatic logic [PERIM_W-1:0] calc_perimeter(kind_t k, logic [DIM_W-1:0] a,
                                                          logic [DIM_W-1:0] b);
        logic [63:0] wa;
        logic [63:0] wb;
        logic [63:0] p;
        logic [63:0] sum_sq;
        logic [63:0] root;
        logic [63:0] trial;
        wa = 64'(a);
        wb = 64'(b);
        case (k)
            KIND_CIRCLE: p = (wa * 64'd2 * PI_FIX) >> 16;
            KIND_RECT: p = (wa + wb) << 1;
            KIND_TRIANGLE: begin
                // Hypotenuse by a bit-by-bit floor square root.
                sum_sq = wa * wa + wb * wb;
                root = '0;
                for (int i = 16; i >= 0; i--) begin
                    trial = root | (64'd1 << i);
                    if (trial * trial <= sum_sq) root = trial;
                end
                p = wa + wb + root;
            end
            default: p = wa << 2;
        endcase
        if (p > PERIM_CAP) p = PERIM_CAP;
        return p[PERIM_W-1:0];
    endfunction

    // Apply one item to the shadow list and return the beats it causes.
    task automatic sort_and_predict(input shape_item_t it, output sorter_beat_t outs[$]);
        logic [PERIM_W-1:0] p;
        int pos;
        outs = {};
        case (it.op)
            OP_INSERT: begin
                if (it.kind > 3'(KIND_SQUARE)) begin
                    outs.push_back('{2'd0, '0, '0, STAT_BAD_KIND, 1'b1});
                end else begin
                    p = calc_perimeter(kind_t'(it.kind[1:0]), it.dim_a, it.dim_b);
                    if (shadow_count >= STORE_DEPTH) begin
                        outs.push_back('{it.kind[1:0], p, it.price, STAT_FULL, 1'b1});
                    end else begin
                        // New entry goes after every equal key.
                        pos = 0;
                        while (pos < shadow_count && shadow_list[pos].perim <= p) pos++;
                        for (int i = shadow_count; i > pos; i--)
                            shadow_list[i] = shadow_list[i-1];
                        shadow_list[pos] = '{it.kind[1:0], p, it.price};
                        shadow_count++;
                        outs.push_back('{it.kind[1:0], p, it.price, STAT_OK, 1'b1});
                    end
                end
            end
            OP_READ: begin
                if (shadow_count == 0) begin
                    outs.push_back('{2'd0, '0, '0, STAT_EMPTY, 1'b1});
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        outs.push_back('{shadow_list[i].kind, shadow_list[i].perim,
                                         shadow_list[i].price, STAT_OK,
                                         i == shadow_count - 1});
                end
            end
            OP_CLEAR: begin
                shadow_count = 0;
                outs.push_back('{2'd0, '0, '0, STAT_OK, 1'b1});
            end
            default: ;
        endcase
    endtask

    function automatic shape_item_t row_model(op_t op, logic [2:0] kind, logic [DIM_W-1:0] a,
                                              logic [DIM_W-1:0] b, logic [PRICE_W-1:0] pr);
        shape_item_t it;
        it.op = op;
        it.kind = kind;
        it.dim_a = a;
        it.dim_b = b;
        it.price = pr;
        it.known = 1'b0;
        it.want = '0;
        return it;
    endfunction

    function automatic shape_item_t row_known(op_t op, logic [2:0] kind, logic [DIM_W-1:0] a,
                                              logic [DIM_W-1:0] b, logic [PRICE_W-1:0] pr,
                                              kind_t wk, logic [PERIM_W-1:0] wp,
                                              logic [PRICE_W-1:0] wpr, status_t ws);
        shape_item_t it;
        it = row_model(op, kind, a, b, pr);
        it.known = 1'b1;
        it.want = '{wk, wp, wpr, ws, 1'b1};
        return it;
    endfunction

    // Random dimension: small values for equal keys, extremes, or the full range.
    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 3))
            0: return DIM_W'($urandom_range(0, 6));
            1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return DIM_W'($urandom());
        endcase
    endfunction

    function automatic shape_item_t rand_insert();
        logic [2:0] k;
        if ($urandom_range(0, 11) == 0) k = 3'($urandom_range(4, 7));
        else k = 3'($urandom_range(0, 3));
        return row_model(OP_INSERT, k, rand_dim(), rand_dim(), PRICE_W'($urandom()));
    endfunction

    // Offer one beat on the input side and record its results once accepted.
    task automatic send_beat(input shape_item_t it);
        int gap;
        sorter_beat_t outs[$];
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.price, it.dim_b, it.dim_a};
        s_tuser <= {it.kind, it.op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sort_and_predict(it, outs);
        if (it.known && outs.size() != 0) outs = '{it.want};
        foreach (outs[i]) pending_beats.push_back(outs[i]);
        if (it.op != OP_NOP) sent_items++;
    endtask

    // Result side: check each accepted beat, then choose the next ready level.
    initial begin
        sorter_beat_t got;
        sorter_beat_t want;
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = '{m_tuser[1:0], m_tdata[PERIM_W-1:0],
                        m_tdata[PERIM_W+PRICE_W-1:PERIM_W], status_t'(m_tuser[3:2]), m_tlast};
                if (pending_beats.size() == 0) begin
                    $display("%0t: unexpected beat kind %0d perim %0d price %0d status %0d last %0d",
                             $time, got.kind, got.perim, got.price, got.status, got.last);
                    err_count++;
                end else begin
                    want = pending_beats.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected kind %0d perim %0d price %0d status %0d last %0d",
                                 $time, want.kind, want.perim, want.price, want.status, want.last);
                        $display("%0t:          actual   kind %0d perim %0d price %0d status %0d last %0d",
                                 $time, got.kind, got.perim, got.price, got.status, got.last);
                        err_count++;
                    end
                end
            end
            if (hold_long) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    // A long hold-off on the result side so the block stalls its output and then its input.
    initial begin
        wait (rand_started);
        repeat (30) @(posedge aclk);
        hold_long <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        hold_long <= 1'b0;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // Stimulus: directed rows first, then random episodes.
    initial begin
        shape_item_t script[$];
        int n;
        int mode;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        script.push_back(row_known(OP_READ, 3'(KIND_CIRCLE), 16'h0000, 16'h0000, 16'h0000,
                                   KIND_CIRCLE, 19'd0, 16'h0000, STAT_EMPTY));
        script.push_back(row_known(OP_INSERT, KIND_BAD_LO, 16'hffff, 16'hffff, 16'hffff,
                                   KIND_CIRCLE, 19'd0, 16'h0000, STAT_BAD_KIND));
        script.push_back(row_known(OP_INSERT, KIND_BAD_HI, 16'h0000, 16'h0000, 16'h0000,
                                   KIND_CIRCLE, 19'd0, 16'h0000, STAT_BAD_KIND));
        script.push_back(row_model(OP_NOP, 3'(KIND_RECT), 16'h1234, 16'h5678, 16'h9abc));
        script.push_back(row_known(OP_INSERT, 3'(KIND_SQUARE), 16'h0000, 16'h0000, 16'h0000,
                                   KIND_SQUARE, 19'd0, 16'h0000, STAT_OK));
        script.push_back(row_known(OP_INSERT, 3'(KIND_SQUARE), 16'hffff, 16'h1234, 16'hffff,
                                   KIND_SQUARE, 19'd262140, 16'hffff, STAT_OK));
        script.push_back(row_model(OP_INSERT, 3'(KIND_CIRCLE), 16'hffff, 16'hffff, 16'h1357));
        script.push_back(row_model(OP_INSERT, 3'(KIND_CIRCLE), 16'h0100, 16'h0000, 16'h2468));
        script.push_back(row_known(OP_INSERT, 3'(KIND_RECT), 16'hffff, 16'hffff, 16'haaaa,
                                   KIND_RECT, 19'd262140, 16'haaaa, STAT_OK));
        // Rectangle and square with the same key: the later one must follow.
        script.push_back(row_model(OP_INSERT, 3'(KIND_RECT), 16'h0100, 16'h0080, 16'h0001));
        script.push_back(row_model(OP_INSERT, 3'(KIND_SQUARE), 16'h00c0, 16'h0000, 16'h0002));
        script.push_back(row_model(OP_INSERT, 3'(KIND_TRIANGLE), 16'h0003, 16'h0004, 16'h5555));
        script.push_back(row_model(OP_INSERT, 3'(KIND_TRIANGLE), 16'hffff, 16'hffff, 16'h0f0f));
        script.push_back(row_model(OP_INSERT, 3'(KIND_TRIANGLE), 16'h0000, 16'h0000, 16'hf0f0));
        script.push_back(row_model(OP_INSERT, 3'(KIND_CIRCLE), 16'h0000, 16'hffff, 16'h0000));
        script.push_back(row_model(OP_READ, 3'(KIND_CIRCLE), 16'h0000, 16'h0000, 16'h0000));
        script.push_back(row_known(OP_INSERT, KIND_BAD_MID, 16'h0010, 16'h0020, 16'h0030,
                                   KIND_CIRCLE, 19'd0, 16'h0000, STAT_BAD_KIND));
        script.push_back(row_model(OP_READ, 3'(KIND_RECT), 16'hffff, 16'hffff, 16'hffff));
        script.push_back(row_known(OP_CLEAR, 3'(KIND_CIRCLE), 16'h0000, 16'h0000, 16'h0000,
                                   KIND_CIRCLE, 19'd0, 16'h0000, STAT_OK));
        script.push_back(row_known(OP_READ, 3'(KIND_CIRCLE), 16'h0000, 16'h0000, 16'h0000,
                                   KIND_CIRCLE, 19'd0, 16'h0000, STAT_EMPTY));
        script.push_back(row_model(OP_INSERT, 3'(KIND_RECT), 16'h0001, 16'h0000, 16'h0007));
        script.push_back(row_model(OP_READ, 3'(KIND_CIRCLE), 16'h0000, 16'h0000, 16'h0000));
        script.push_back(row_known(OP_CLEAR, 3'(KIND_SQUARE), 16'hffff, 16'hffff, 16'hffff,
                                   KIND_CIRCLE, 19'd0, 16'h0000, STAT_OK));
        foreach (script[i]) send_beat(script[i]);

        rand_started = 1'b1;
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                // Well-formed run: clear, fill (sometimes past full), read back.
                send_beat(row_model(OP_CLEAR, 3'($urandom()), rand_dim(), rand_dim(),
                                    PRICE_W'($urandom())));
                if ($urandom_range(0, 3) == 0) n = $urandom_range(16, 20);
                else n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    send_beat(rand_insert());
                    if ($urandom_range(0, 6) == 0)
                        send_beat(row_model(OP_READ, 3'($urandom()), rand_dim(), rand_dim(),
                                            PRICE_W'($urandom())));
                end
                send_beat(row_model(OP_READ, 3'($urandom()), rand_dim(), rand_dim(),
                                    PRICE_W'($urandom())));
            end else begin
                // Noise: any operation, any kind, raw fields.
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_beat(row_model(op_t'($urandom_range(0, 3)), 3'($urandom()),
                                        DIM_W'($urandom()), DIM_W'($urandom()),
                                        PRICE_W'($urandom())));
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // Drain outstanding results, then give the block time for strays.
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
